>>> src/nbbsr_pkg.sv
// Package for the nine-bit bus slave receiver: request types, codes and checksum step.
package nbbsr_pkg;

    // Request codes on the input channel
    localparam logic [1:0] OP_WORD    = 2'd0;
    localparam logic [1:0] OP_TIMEOUT = 2'd1;
    localparam logic [1:0] OP_UART    = 2'd2;

    // Result kinds
    localparam logic [1:0] KIND_ACK    = 2'd0;
    localparam logic [1:0] KIND_DATA   = 2'd1;
    localparam logic [1:0] KIND_ACCEPT = 2'd2;
    localparam logic [1:0] KIND_ABORT  = 2'd3;

    // Abort reasons
    localparam logic [2:0] ABT_RX_ERR    = 3'd0;
    localparam logic [2:0] ABT_STRAY_NB  = 3'd1;
    localparam logic [2:0] ABT_HDR_CHK   = 3'd2;
    localparam logic [2:0] ABT_ECHO      = 3'd3;
    localparam logic [2:0] ABT_TOO_LONG  = 3'd4;
    localparam logic [2:0] ABT_DATA_CHK  = 3'd5;

    // Configuration register indexes
    localparam int          CFG_IDX_W       = 1;
    localparam logic [0:0]  CFG_OWN_ADDRESS = 1'd0;
    localparam logic [0:0]  CFG_MAX_DATA_LEN = 1'd1;

    // Reset values and limits
    localparam logic [7:0] OWN_ADDRESS_RST  = 8'd255;
    localparam logic [7:0] MAX_DATA_LEN_RST = 8'd20;
    localparam logic [7:0] CHK_SEED         = 8'hFF;
    localparam logic [2:0] START_LIMIT      = 3'd5;

    // Input request
    typedef struct packed {
        logic [1:0] op;
        logic [7:0] word_data;
        logic       ninth_bit;
    } t_rx_in;

    // Result item
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] byte_value;
        logic [7:0] sender;
        logic [7:0] command;
        logic [7:0] length;
        logic       repeated;
        logic [2:0] abort_reason;
    } t_rx_out;

    // One checksum step: XOR then rotate right by one
    function automatic logic [7:0] chk_next(input logic [7:0] chk, input logic [7:0] b);
        logic [7:0] x;
        x = chk ^ b;
        return {x[0], x[7:1]};
    endfunction

endpackage

>>> src/nine_bit_bus_slave_receiver.sv
// Top level: slave receiver for a multidrop nine-bit bus.
//
// Usage
//   Input channel (i_in_valid / o_in_ready / i_in_data) carries one request
//   per received bus word, receive timeout or UART error. Output channel
//   (o_out_valid / i_out_ready / o_out_data) carries ack bytes to transmit,
//   tentative data bytes, and packet accept or abort notices.
//   Configuration is a plain write port (i_cfg_we, i_cfg_idx, i_cfg_data):
//   index 0 is the own address, index 1 the largest data length.
// Timing
//   A request is decoded in the cycle it is accepted; its result, if any,
//   sits in the output register from the next cycle on. One request per cycle
//   is taken while o_in_ready is high; the phase update is a single pass of
//   the decode logic between the state registers and the result register.
// Stalls and reset
//   o_in_ready stays high while the output register is empty or being
//   drained in the same cycle; a held result blocks further requests only
//   while i_out_ready is low. Reset empties the output register, returns
//   the receiver to idle and restores the configuration defaults.
module nine_bit_bus_slave_receiver (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [nbbsr_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [7:0]                      i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  nbbsr_pkg::t_rx_in               i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output nbbsr_pkg::t_rx_out              o_out_data
);
    import nbbsr_pkg::*;

    // Phase codes
    localparam logic [3:0] PH_IDLE   = 4'd0;
    localparam logic [3:0] PH_SENDER = 4'd1;
    localparam logic [3:0] PH_HCHK   = 4'd2;
    localparam logic [3:0] PH_HECHO  = 4'd3;
    localparam logic [3:0] PH_SEQ    = 4'd4;
    localparam logic [3:0] PH_CMD    = 4'd5;
    localparam logic [3:0] PH_LEN    = 4'd6;
    localparam logic [3:0] PH_DATA   = 4'd7;
    localparam logic [3:0] PH_DCHK   = 4'd8;
    localparam logic [3:0] PH_DECHO  = 4'd9;

    logic [7:0] r_own_addr, r_max_len;
    logic [3:0] r_phase, n_phase;
    logic [7:0] r_chk, n_chk;
    logic [7:0] r_echo, n_echo;
    logic [7:0] r_sender, n_sender;
    logic [7:0] r_command, n_command;
    logic [7:0] r_length, n_length;
    logic [7:0] r_seen, n_seen;
    logic [7:0] r_seq, n_seq;
    logic [7:0] r_st_seq, n_st_seq;
    logic       r_st_valid, n_st_valid;
    logic [7:0] r_st_sender, n_st_sender;
    logic [2:0] r_start_cnt, n_start_cnt;
    logic       r_out_valid;
    t_rx_out    r_out, n_out;
    logic       res_v;
    logic       do_abort;
    logic [2:0] ab_reason;
    logic       accept;
    logic [7:0] d;
    logic       nb;
    logic [7:0] seen_inc;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign accept      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign d           = i_in_data.word_data;
    assign nb          = i_in_data.ninth_bit;
    assign seen_inc    = r_seen + 8'd1;

    // Per-request decode and phase update
    always_comb begin
        n_phase     = r_phase;
        n_chk       = r_chk;
        n_echo      = r_echo;
        n_sender    = r_sender;
        n_command   = r_command;
        n_length    = r_length;
        n_seen      = r_seen;
        n_seq       = r_seq;
        n_st_seq    = r_st_seq;
        n_st_valid  = r_st_valid;
        n_st_sender = r_st_sender;
        n_start_cnt = r_start_cnt;
        n_out       = '0;
        res_v       = 1'b0;
        do_abort    = 1'b0;
        ab_reason   = ABT_RX_ERR;
        if (accept) begin
            if (r_phase == PH_IDLE) begin
                // an address word equal to the own address opens a packet; nothing else does
                if (i_in_data.op == OP_WORD && nb) begin
                    if (r_start_cnt > START_LIMIT) begin
                        n_st_valid = 1'b0;
                    end else begin
                        n_start_cnt = r_start_cnt + 3'd1;
                    end
                    if (d == r_own_addr) begin
                        n_chk   = chk_next(CHK_SEED, r_own_addr);
                        n_phase = PH_SENDER;
                    end
                end
            end else if (i_in_data.op != OP_WORD) begin
                do_abort  = 1'b1;
                ab_reason = ABT_RX_ERR;
            end else begin
                case (r_phase)
                    PH_SENDER, PH_SEQ, PH_CMD: begin
                        if (nb) begin
                            do_abort  = 1'b1;
                            ab_reason = ABT_STRAY_NB;
                        end else begin
                            n_chk = chk_next(r_chk, d);
                            case (r_phase)
                                PH_SENDER: begin
                                    n_sender = d;
                                    n_phase  = PH_HCHK;
                                end
                                PH_SEQ: begin
                                    n_seq   = d;
                                    n_phase = PH_CMD;
                                end
                                default: begin
                                    n_command = d;
                                    n_phase   = PH_LEN;
                                end
                            endcase
                        end
                    end
                    PH_HCHK, PH_DCHK: begin
                        if (nb || d != r_chk) begin
                            do_abort  = 1'b1;
                            ab_reason = (r_phase == PH_HCHK) ? ABT_HDR_CHK : ABT_DATA_CHK;
                        end else begin
                            // send the inverted checksum and expect it back
                            n_echo         = ~r_chk;
                            res_v          = 1'b1;
                            n_out.kind     = KIND_ACK;
                            n_out.byte_value = ~r_chk;
                            n_phase        = (r_phase == PH_HCHK) ? PH_HECHO : PH_DECHO;
                        end
                    end
                    PH_HECHO: begin
                        if (nb || d != r_echo) begin
                            do_abort  = 1'b1;
                            ab_reason = ABT_ECHO;
                        end else begin
                            n_phase = PH_SEQ;
                        end
                    end
                    PH_LEN: begin
                        if (nb) begin
                            do_abort  = 1'b1;
                            ab_reason = ABT_STRAY_NB;
                        end else begin
                            n_length = d;
                            n_chk    = chk_next(r_chk, d);
                            if (d > r_max_len) begin
                                do_abort  = 1'b1;
                                ab_reason = ABT_TOO_LONG;
                            end else begin
                                n_seen  = 8'd0;
                                n_phase = (d == 8'd0) ? PH_DCHK : PH_DATA;
                            end
                        end
                    end
                    PH_DATA: begin
                        if (nb) begin
                            do_abort  = 1'b1;
                            ab_reason = ABT_STRAY_NB;
                        end else begin
                            n_chk  = chk_next(r_chk, d);
                            n_seen = seen_inc;
                            if (seen_inc >= r_length) begin
                                n_phase = PH_DCHK;
                            end
                            res_v            = 1'b1;
                            n_out.kind       = KIND_DATA;
                            n_out.byte_value = d;
                        end
                    end
                    PH_DECHO: begin
                        if (nb || d != r_echo) begin
                            do_abort  = 1'b1;
                            ab_reason = ABT_ECHO;
                        end else begin
                            // accept; repeat check against the previous packet
                            res_v          = 1'b1;
                            n_out.kind     = KIND_ACCEPT;
                            n_out.sender   = r_sender;
                            n_out.command  = r_command;
                            n_out.length   = r_length;
                            n_out.repeated = r_st_valid && (r_st_seq == r_seq) &&
                                             (r_st_sender == r_sender);
                            n_st_seq       = r_seq;
                            n_st_sender    = r_sender;
                            n_st_valid     = 1'b1;
                            n_phase        = PH_IDLE;
                        end
                    end
                    default: begin
                        n_phase = PH_IDLE;
                    end
                endcase
            end
            // abort notice overrides anything set above
            if (do_abort) begin
                n_out              = '0;
                res_v              = 1'b1;
                n_out.kind         = KIND_ABORT;
                n_out.abort_reason = ab_reason;
                n_phase            = PH_IDLE;
            end
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_addr <= OWN_ADDRESS_RST;
            r_max_len  <= MAX_DATA_LEN_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_OWN_ADDRESS:  r_own_addr <= i_cfg_data;
                CFG_MAX_DATA_LEN: r_max_len  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Receiver state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_chk       <= CHK_SEED;
            r_echo      <= 8'd0;
            r_sender    <= 8'd0;
            r_command   <= 8'd0;
            r_length    <= 8'd0;
            r_seen      <= 8'd0;
            r_seq       <= 8'd0;
            r_st_seq    <= 8'd0;
            r_st_valid  <= 1'b0;
            r_st_sender <= 8'd0;
            r_start_cnt <= 3'd0;
        end else begin
            r_phase     <= n_phase;
            r_chk       <= n_chk;
            r_echo      <= n_echo;
            r_sender    <= n_sender;
            r_command   <= n_command;
            r_length    <= n_length;
            r_seen      <= n_seen;
            r_seq       <= n_seq;
            r_st_seq    <= n_st_seq;
            r_st_valid  <= n_st_valid;
            r_st_sender <= n_st_sender;
            r_start_cnt <= n_start_cnt;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_out_valid <= res_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && res_v) begin
            r_out <= n_out;
        end
    end

endmodule

>>> tb/sv/tb_top.sv
// Self-checking testbench for the nine-bit bus slave receiver.
`timescale 1ns / 1ps

module tb_top;
    import nbbsr_pkg::*;

    // Unused request code, treated by the block as a UART error
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int         HOLD_CYCLES = 300;

    // Receiver phases as tracked by the predictor
    typedef enum logic [3:0] {
        ST_IDLE, ST_SENDER, ST_HDR_CHK, ST_HDR_ECHO, ST_SEQ, ST_CMD, ST_LEN,
        ST_DATA, ST_DATA_CHK, ST_DATA_ECHO
    } rx_phase_e;

    // Ways of spoiling a generated packet
    typedef enum int {DMG_NONE, DMG_FLIP, DMG_NINTH, DMG_FAULT, DMG_CUT} damage_e;

    logic                 i_clk;
    logic                 i_rst_n    = 1'b0;
    logic                 i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx  = '0;
    logic [7:0]           i_cfg_data = '0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    t_rx_in               i_in_data  = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    t_rx_out              o_out_data;

    nine_bit_bus_slave_receiver u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // Bus words waiting to be offered, and results still owed by the block
    t_rx_in  rx_words_q[$];
    t_rx_out due_results[$];

    int  words_queued   = 0;
    int  words_accepted = 0;
    int  results_seen   = 0;
    int  error_count    = 0;
    int  reg_writes     = 0;
    int  sender_idle_pct = 0;
    int  rcvr_idle_pct   = 0;
    int  holds_asked    = 0;
    int  holds_granted  = 0;
    int  stall_left     = 0;
    logic req_taken     = 1'b0;

    // Predictor copy of configuration and receiver state
    logic [7:0] cfg_own = OWN_ADDRESS_RST;
    logic [7:0] cfg_max = MAX_DATA_LEN_RST;
    rx_phase_e  rx_phase = ST_IDLE;
    logic [7:0] run_chk  = CHK_SEED;
    logic [7:0] echo_due = '0;
    logic [7:0] pkt_sender = '0, pkt_cmd = '0, pkt_len = '0, pkt_seq = '0;
    logic [7:0] data_count = '0;
    logic [7:0] last_seq = '0, stored_from = '0;
    logic       last_valid  = 1'b0;
    logic [2:0] starts_seen = '0;

    int accepts_seen = 0, repeats_seen = 0, data_seen = 0, acks_seen = 0;
    int abort_counts[6];

    // Generator memory for repeated sequence numbers
    logic [7:0] prev_from = '0, prev_seq = '0;

    // Clock, 2 ns period
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Hard limit on the run
    initial begin
        #400000;
        $display("Verification failed");
        $finish;
    end

    function automatic logic [7:0] rotr_xor(input logic [7:0] acc, input logic [7:0] b);
        logic [7:0] x;
        x = acc ^ b;
        return {x[0], x[7:1]};
    endfunction

    function automatic t_rx_in bus_word(input logic [7:0] d, input logic nb);
        t_rx_in w;
        w.op        = OP_WORD;
        w.word_data = d;
        w.ninth_bit = nb;
        return w;
    endfunction

    // Timeout, UART error or the unused code, with random payload bits
    function automatic t_rx_in line_fault();
        t_rx_in w;
        case ($urandom_range(2))
            0:       w.op = OP_TIMEOUT;
            1:       w.op = OP_UART;
            default: w.op = OP_UNUSED;
        endcase
        w.word_data = 8'($urandom_range(255));
        w.ninth_bit = 1'($urandom_range(1));
        return w;
    endfunction

    // Predict the result, if any, of one accepted request
    task automatic step_receiver(input t_rx_in req);
        t_rx_out    res;
        logic       emit, fail, send_ack;
        logic [2:0] why;
        logic [7:0] d;
        logic       nb;
        res = '0;
        emit = 1'b0;
        fail = 1'b0;
        send_ack = 1'b0;
        why = ABT_RX_ERR;
        d = req.word_data;
        nb = req.ninth_bit;
        if (rx_phase == ST_IDLE) begin
            // only address words count while idle
            if (req.op == OP_WORD && nb) begin
                if (starts_seen > START_LIMIT)
                    last_valid = 1'b0;
                else
                    starts_seen = starts_seen + 3'd1;
                if (d == cfg_own) begin
                    run_chk = rotr_xor(CHK_SEED, cfg_own);
                    rx_phase = ST_SENDER;
                end
            end
        end else if (req.op != OP_WORD) begin
            fail = 1'b1;
            why = ABT_RX_ERR;
        end else begin
            case (rx_phase)
                ST_SENDER: begin
                    if (nb) begin
                        fail = 1'b1;
                        why = ABT_STRAY_NB;
                    end else begin
                        pkt_sender = d;
                        run_chk = rotr_xor(run_chk, d);
                        rx_phase = ST_HDR_CHK;
                    end
                end
                ST_HDR_CHK: begin
                    if (nb || d != run_chk) begin
                        fail = 1'b1;
                        why = ABT_HDR_CHK;
                    end else begin
                        send_ack = 1'b1;
                        rx_phase = ST_HDR_ECHO;
                    end
                end
                ST_HDR_ECHO: begin
                    if (nb || d != echo_due) begin
                        fail = 1'b1;
                        why = ABT_ECHO;
                    end else begin
                        rx_phase = ST_SEQ;
                    end
                end
                ST_SEQ, ST_CMD: begin
                    if (nb) begin
                        fail = 1'b1;
                        why = ABT_STRAY_NB;
                    end else begin
                        if (rx_phase == ST_SEQ)
                            pkt_seq = d;
                        else
                            pkt_cmd = d;
                        run_chk = rotr_xor(run_chk, d);
                        rx_phase = (rx_phase == ST_SEQ) ? ST_CMD : ST_LEN;
                    end
                end
                ST_LEN: begin
                    if (nb) begin
                        fail = 1'b1;
                        why = ABT_STRAY_NB;
                    end else begin
                        pkt_len = d;
                        run_chk = rotr_xor(run_chk, d);
                        if (d > cfg_max) begin
                            fail = 1'b1;
                            why = ABT_TOO_LONG;
                        end else begin
                            data_count = '0;
                            rx_phase = (d == 8'd0) ? ST_DATA_CHK : ST_DATA;
                        end
                    end
                end
                ST_DATA: begin
                    if (nb) begin
                        fail = 1'b1;
                        why = ABT_STRAY_NB;
                    end else begin
                        run_chk = rotr_xor(run_chk, d);
                        data_count = data_count + 8'd1;
                        if (data_count >= pkt_len)
                            rx_phase = ST_DATA_CHK;
                        res.kind = KIND_DATA;
                        res.byte_value = d;
                        emit = 1'b1;
                        data_seen++;
                    end
                end
                ST_DATA_CHK: begin
                    if (nb || d != run_chk) begin
                        fail = 1'b1;
                        why = ABT_DATA_CHK;
                    end else begin
                        send_ack = 1'b1;
                        rx_phase = ST_DATA_ECHO;
                    end
                end
                ST_DATA_ECHO: begin
                    if (nb || d != echo_due) begin
                        fail = 1'b1;
                        why = ABT_ECHO;
                    end else begin
                        // repeat flag uses the stored values before this accept
                        res.kind = KIND_ACCEPT;
                        res.sender = pkt_sender;
                        res.command = pkt_cmd;
                        res.length = pkt_len;
                        res.repeated = last_valid && last_seq == pkt_seq &&
                                       stored_from == pkt_sender;
                        last_seq = pkt_seq;
                        stored_from = pkt_sender;
                        last_valid = 1'b1;
                        rx_phase = ST_IDLE;
                        emit = 1'b1;
                        accepts_seen++;
                        if (res.repeated)
                            repeats_seen++;
                    end
                end
                default: rx_phase = ST_IDLE;
            endcase
        end
        if (send_ack) begin
            echo_due = ~run_chk;
            res.kind = KIND_ACK;
            res.byte_value = echo_due;
            emit = 1'b1;
            acks_seen++;
        end
        if (fail) begin
            res = '0;
            res.kind = KIND_ABORT;
            res.abort_reason = why;
            rx_phase = ST_IDLE;
            emit = 1'b1;
            abort_counts[why]++;
        end
        if (emit)
            due_results.push_back(res);
    endtask

    task automatic check_field(input string what, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
            error_count++;
        end
    endtask

    // Build one packet with correct checksums and echoes, maybe spoil it, queue it
    task automatic queue_packet(input logic [7:0] addr, input logic [7:0] from,
                                input logic [7:0] seq, input logic [7:0] cmd,
                                input int len, input damage_e dmg);
        t_rx_in     words[$];
        t_rx_in     w;
        logic [7:0] c, b;
        int         n_data, pos;
        words.push_back(bus_word(addr, 1'b1));
        c = rotr_xor(CHK_SEED, addr);
        c = rotr_xor(c, from);
        words.push_back(bus_word(from, 1'b0));
        words.push_back(bus_word(c, 1'b0));
        words.push_back(bus_word(~c, 1'b0));
        c = rotr_xor(c, seq);
        words.push_back(bus_word(seq, 1'b0));
        c = rotr_xor(c, cmd);
        words.push_back(bus_word(cmd, 1'b0));
        c = rotr_xor(c, len[7:0]);
        words.push_back(bus_word(len[7:0], 1'b0));
        // an over-long packet dies at its length, so only a little data follows
        n_data = (len > cfg_max) ? 2 : len;
        for (int i = 0; i < n_data; i++) begin
            b = 8'($urandom_range(255));
            c = rotr_xor(c, b);
            words.push_back(bus_word(b, 1'b0));
        end
        words.push_back(bus_word(c, 1'b0));
        words.push_back(bus_word(~c, 1'b0));
        if (dmg != DMG_NONE) begin
            pos = $urandom_range(words.size() - 1);
            w = words[pos];
            case (dmg)
                DMG_FLIP:  w.word_data = w.word_data ^ 8'($urandom_range(255, 1));
                DMG_NINTH: w.ninth_bit = ~w.ninth_bit;
                DMG_FAULT: w = line_fault();
                default:   ;
            endcase
            words[pos] = w;
            if (dmg == DMG_CUT)
                words = words[0:pos];
        end
        foreach (words[i]) begin
            rx_words_q.push_back(words[i]);
            words_queued++;
        end
    endtask

    // Short directed opening: idle noise, accept, repeat, mismatch, fault
    task automatic queue_directed;
        rx_words_q.push_back(bus_word(8'hFF, 1'b0));
        rx_words_q.push_back(line_fault());
        rx_words_q.push_back(line_fault());
        rx_words_q.push_back(line_fault());
        words_queued += 4;
        queue_packet(cfg_own, 8'hFF, 8'h00, 8'hFF, 0, DMG_NONE);
        queue_packet(cfg_own, 8'hFF, 8'h00, 8'h00, 0, DMG_NONE);
        rx_words_q.push_back(bus_word(~cfg_own, 1'b1));
        rx_words_q.push_back(bus_word(cfg_own, 1'b1));
        rx_words_q.push_back(bus_word(8'h12, 1'b0));
        rx_words_q.push_back(line_fault());
        words_queued += 4;
    endtask

    // Random traffic: mostly well-formed packets, some spoilt, some noise
    task automatic queue_random(input int n_items, input bit with_longest);
        int         first, len, cap;
        logic [7:0] addr, from, seq;
        damage_e    dmg;
        bit         longest_done;
        first = words_queued;
        longest_done = 1'b0;
        cap = (cfg_max < 8) ? cfg_max : 8;
        while (words_queued - first < n_items) begin
            if ($urandom_range(99) < 25) begin
                case ($urandom_range(2))
                    0:       rx_words_q.push_back(bus_word(8'($urandom_range(255)), 1'b0));
                    1:       rx_words_q.push_back(line_fault());
                    default: rx_words_q.push_back(bus_word(8'($urandom_range(255)), 1'b1));
                endcase
                words_queued++;
            end else begin
                addr = ($urandom_range(99) < 88) ? cfg_own : 8'($urandom_range(255));
                if ($urandom_range(99) < 15) begin
                    from = prev_from;
                    seq = prev_seq;
                end else begin
                    from = 8'($urandom_range(255));
                    seq = 8'($urandom_range(255));
                end
                prev_from = from;
                prev_seq = seq;
                if (with_longest && !longest_done) begin
                    len = cfg_max;
                    longest_done = 1'b1;
                end else if (cfg_max < 255 && $urandom_range(99) < 6) begin
                    len = $urandom_range(255, cfg_max + 1);
                end else begin
                    len = $urandom_range(cap);
                end
                dmg = ($urandom_range(99) < 20) ? damage_e'($urandom_range(4, 1)) : DMG_NONE;
                queue_packet(addr, from, seq, 8'($urandom_range(255)), len, dmg);
            end
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_OWN_ADDRESS)
            cfg_own = val;
        else
            cfg_max = val;
        reg_writes++;
    endtask

    // Sender stays quiet until every request is taken and every result is back
    task automatic wait_drained;
        do @(negedge i_clk);
        while (words_accepted != words_queued || due_results.size() != 0);
        repeat (3) @(negedge i_clk);
    endtask

    task automatic run_phase(input logic [7:0] own, input logic [7:0] max_len,
                             input int snd_pct, input int rcv_pct, input int n_items,
                             input bit directed, input bit longest, input bit hold);
        wait_drained();
        write_reg(CFG_OWN_ADDRESS, own);
        write_reg(CFG_MAX_DATA_LEN, max_len);
        @(posedge i_clk);
        sender_idle_pct = snd_pct;
        rcvr_idle_pct = rcv_pct;
        if (hold)
            holds_asked++;
        if (directed)
            queue_directed();
        queue_random(n_items, longest);
    endtask

    // Request driver: offers the next queued bus word, holding it until taken
    always @(negedge i_clk) begin
        if (!i_in_valid || req_taken) begin
            if (rx_words_q.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
                i_in_valid <= 1'b1;
                i_in_data  <= rx_words_q.pop_front();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Result receiver: random stalls plus the occasional long hold-off
    always @(negedge i_clk) begin
        if (holds_granted < holds_asked) begin
            holds_granted++;
            stall_left = HOLD_CYCLES;
        end
        if (stall_left > 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= rcvr_idle_pct);
        end
    end

    // Monitor: predict on accepted requests, check delivered results
    always @(posedge i_clk) begin
        t_rx_out want;
        req_taken <= i_rst_n && i_in_valid && o_in_ready;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                step_receiver(i_in_data);
                words_accepted++;
            end
            if (o_out_valid && i_out_ready) begin
                results_seen++;
                if (due_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got %h", $time,
                             o_out_data);
                    error_count++;
                end else begin
                    want = due_results.pop_front();
                    check_field("kind", 8'(want.kind), 8'(o_out_data.kind));
                    check_field("byte_value", want.byte_value, o_out_data.byte_value);
                    check_field("sender", want.sender, o_out_data.sender);
                    check_field("command", want.command, o_out_data.command);
                    check_field("length", want.length, o_out_data.length);
                    check_field("repeated", 8'(want.repeated), 8'(o_out_data.repeated));
                    check_field("abort_reason", 8'(want.abort_reason),
                                8'(o_out_data.abort_reason));
                end
            end
        end
    end

    // Reset, then the configuration phases in turn
    initial begin
        foreach (abort_counts[i])
            abort_counts[i] = 0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        run_phase(8'h00, 8'd20, 19, 60, 200, 1'b1, 1'b0, 1'b0);
        run_phase(8'hFF, 8'd0, 19, 60, 200, 1'b0, 1'b0, 1'b0);
        run_phase(8'($urandom_range(255)), 8'd255, 19, 60, 450, 1'b0, 1'b1, 1'b1);
        run_phase(8'($urandom_range(255)), 8'($urandom_range(30, 1)), 60, 19, 300,
                  1'b0, 1'b0, 1'b0);
        run_phase(8'h80, 8'd1, 60, 19, 200, 1'b0, 1'b0, 1'b0);
        run_phase(8'($urandom_range(255)), 8'd20, 0, 0, 250, 1'b0, 1'b0, 1'b0);
        wait_drained();
        $display("Run: %0d bus requests, %0d register writes, %0d results checked",
                 words_accepted, reg_writes, results_seen);
        $display("Accepted %0d (%0d repeats), %0d data bytes, %0d acks,",
                 accepts_seen, repeats_seen, data_seen, acks_seen);
        $display("aborts %0d/%0d/%0d/%0d/%0d/%0d", abort_counts[0], abort_counts[1],
                 abort_counts[2], abort_counts[3], abort_counts[4], abort_counts[5]);
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
